[sv/sfr_pkg.sv]
// Shared constants, register codes and controller/datapath interface types.
package sfr_pkg;

  localparam int BUFFER_BYTES = 32;
  localparam int MAX_BURST    = 32;
  localparam int STORE_CAP    = (BUFFER_BYTES < MAX_BURST) ? BUFFER_BYTES : MAX_BURST;
  localparam int STORE_AW     = (STORE_CAP > 1) ? $clog2(STORE_CAP) : 1;
  localparam int NUM_W        = $clog2(STORE_CAP + 1);

  localparam logic [7:0] START_RESET = 8'hE5;
  localparam logic [7:0] SEED_RESET  = 8'hD3;
  localparam logic [7:0] TERM_RESET  = 8'h0A;

  typedef enum logic [2:0] {
    REG_LINE_MODE    = 3'd0,
    REG_CHECK_ENABLE = 3'd1,
    REG_START_MARKER = 3'd2,
    REG_CHECK_SEED   = 3'd3,
    REG_LINE_TERM    = 3'd4
  } reg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;       // write the received byte into the frame store
    logic xor_upd;     // fold the received byte into the running checksum
    logic load_len;    // take the received byte as declared length
    logic clear;       // abandon the frame in progress
    logic emit_start;  // snapshot the finished frame for the burst
    logic emit_line;   // counted length rather than declared length
    logic emit_step;   // move one result into the output register
  } sfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic line_mode;
    logic check_enable;
    logic mode_write;
    logic is_term;
    logic is_start;
    logic is_zero;
    logic data_done;
    logic check_ok;
    logic emit_last;
    logic out_hold;
  } sfr_stat_t;

endpackage

[sv/sfr_ctrl.sv]
// Frame receive controller: framing phase and burst sequencing.
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sfr_stat_t stat_i,
  output sfr_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_WAIT  = 5'b00001,
    ST_LEN   = 5'b00010,
    ST_DATA  = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q == ST_EMIT);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    if (stat_i.mode_write) begin
      cmd_o.clear = 1'b1;
      state_d     = ST_WAIT;
    end else if (state_q == ST_EMIT) begin
      if (!stat_i.out_hold) begin
        cmd_o.emit_step = 1'b1;
        if (stat_i.emit_last) begin
          state_d = ST_WAIT;
        end
      end
    end else if (accept) begin
      if (stat_i.line_mode) begin
        if (stat_i.is_term) begin
          cmd_o.emit_start = 1'b1;
          cmd_o.emit_line  = 1'b1;
          state_d          = ST_EMIT;
        end else begin
          cmd_o.store = 1'b1;
        end
      end else begin
        case (state_q)
          ST_WAIT: begin
            if (stat_i.is_start) begin
              state_d = ST_LEN;
            end
          end
          ST_LEN: begin
            cmd_o.load_len = 1'b1;
            state_d        = stat_i.is_zero ? ST_CHECK : ST_DATA;
          end
          ST_DATA: begin
            cmd_o.store   = 1'b1;
            cmd_o.xor_upd = 1'b1;
            if (stat_i.data_done) begin
              state_d = ST_CHECK;
            end
          end
          ST_CHECK: begin
            if (!stat_i.check_enable || stat_i.check_ok) begin
              cmd_o.emit_start = 1'b1;
              state_d          = ST_EMIT;
            end else begin
              // bad check: drop the frame
              state_d = ST_WAIT;
            end
          end
          default: state_d = ST_WAIT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/sfr_dpath.sv]
// Frame receive datapath: registers, frame store, counters, checksum, output stage.
module sfr_dpath
  import sfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       cfg_valid_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  sfr_cmd_t   cmd_i,
  output sfr_stat_t  stat_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic [4:0] byte_position_o,
  output logic [7:0] frame_length_o,
  output logic       last_byte_o,
  output logic       empty_frame_o,
  output logic       truncated_o
);

  localparam logic [7:0]       CapByte = 8'(STORE_CAP);
  localparam logic [NUM_W-1:0] CapNum  = NUM_W'(STORE_CAP);

  logic             line_mode_q, check_en_q;
  logic [7:0]       start_q, seed_q, term_q;
  logic [7:0]       count_q, declared_q, xor_q;
  logic             ovf_q;
  logic [7:0]       count_inc;
  logic             fits;

  logic [NUM_W-1:0]    em_num_q;
  logic [7:0]          em_len_q;
  logic                em_ovf_q;
  logic [STORE_AW-1:0] rd_idx_q;
  logic                em_empty, em_last;

  logic                out_valid_q;
  logic [7:0]          out_byte_q, out_len_q;
  logic [4:0]          out_pos_q;
  logic                out_last_q, out_empty_q, out_trunc_q;

  logic [7:0] store_mem [STORE_CAP];

  assign count_inc = (count_q == 8'hFF) ? count_q : count_q + 8'd1;
  assign fits      = (count_q < CapByte);
  assign em_empty  = (em_num_q == '0);
  assign em_last   = em_empty || ((NUM_W'(rd_idx_q) + NUM_W'(1)) == em_num_q);

  always_comb begin
    stat_o              = '0;
    stat_o.line_mode    = line_mode_q;
    stat_o.check_enable = check_en_q;
    stat_o.mode_write   = cfg_valid_i && (cfg_index_i == REG_LINE_MODE);
    stat_o.is_term      = (rx_byte_i == term_q);
    stat_o.is_start     = (rx_byte_i == start_q);
    stat_o.is_zero      = (rx_byte_i == 8'd0);
    stat_o.data_done    = (count_inc == declared_q);
    stat_o.check_ok     = (rx_byte_i == xor_q);
    stat_o.emit_last    = em_last;
    stat_o.out_hold     = out_valid_q & out_stall_i;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode_q <= 1'b1;
      check_en_q  <= 1'b0;
      start_q     <= START_RESET;
      seed_q      <= SEED_RESET;
      term_q      <= TERM_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LINE_MODE:    line_mode_q <= cfg_data_i[0];
        REG_CHECK_ENABLE: check_en_q  <= cfg_data_i[0];
        REG_START_MARKER: start_q     <= cfg_data_i;
        REG_CHECK_SEED:   seed_q      <= cfg_data_i;
        REG_LINE_TERM:    term_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      declared_q <= '0;
      xor_q      <= SEED_RESET;
      ovf_q      <= 1'b0;
    end else if (cmd_i.clear || cmd_i.emit_start) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load_len) begin
      declared_q <= rx_byte_i;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      xor_q      <= seed_q;
    end else if (cmd_i.store) begin
      count_q <= count_inc;
      if (!fits) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.xor_upd) begin
        xor_q <= xor_q ^ rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && fits) begin
      store_mem[count_q[STORE_AW-1:0]] <= rx_byte_i;
    end
  end

  // Burst snapshot and read pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_num_q <= '0;
      em_len_q <= '0;
      em_ovf_q <= 1'b0;
      rd_idx_q <= '0;
    end else if (cmd_i.emit_start) begin
      em_num_q <= fits ? count_q[NUM_W-1:0] : CapNum;
      em_len_q <= cmd_i.emit_line ? count_q : declared_q;
      em_ovf_q <= ovf_q;
      rd_idx_q <= '0;
    end else if (cmd_i.emit_step && !em_last) begin
      rd_idx_q <= rd_idx_q + STORE_AW'(1);
    end
  end

  // Output register; the store read lands here directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      out_byte_q  <= em_empty ? 8'd0 : store_mem[rd_idx_q];
      out_pos_q   <= 5'(rd_idx_q);
      out_len_q   <= em_len_q;
      out_last_q  <= em_last;
      out_empty_q <= em_empty;
      out_trunc_q <= em_ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_byte_q;
  assign byte_position_o = out_pos_q;
  assign frame_length_o  = out_len_q;
  assign last_byte_o     = out_last_q;
  assign empty_frame_o   = out_empty_q;
  assign truncated_o     = out_trunc_q;

endmodule

[sv/serial_frame_receiver.sv]
// Byte-stream frame receiver: line and length-prefixed framing with XOR check.
// Each received byte is taken unless input is stalled; the byte that completes
// a frame starts a burst, in which the controller's emit state moves n results
// (one for an empty frame) from the frame store to the output register, one per
// cycle while the output is not stalled; input is stalled while the burst issues.
// Reset (rst_ni, asynchronous, active low) restores register defaults and idles.
module serial_frame_receiver
  import sfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic [4:0] byte_position_o,
  output logic [7:0] frame_length_o,
  output logic       last_byte_o,
  output logic       empty_frame_o,
  output logic       truncated_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  sfr_cmd_t  cmd;
  sfr_stat_t stat;

  assign cfg_ready_o = 1'b1;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sfr_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_byte_i       (rx_byte_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .payload_byte_o  (payload_byte_o),
    .byte_position_o (byte_position_o),
    .frame_length_o  (frame_length_o),
    .last_byte_o     (last_byte_o),
    .empty_frame_o   (empty_frame_o),
    .truncated_o     (truncated_o)
  );

endmodule
